// ===== src/prgs_pkg.sv =====
// ============================================================================
// prgs_pkg
// Shared types, register indexes, codes and helper functions for the
// probabilistic rhythm gate sequencer.
// ============================================================================
package prgs_pkg;

    // request payloads
    typedef struct packed {
        logic       clock_edge;
        logic       reset_edge;
        logic       run_toggle;
        logic [4:0] phrase_bars;
        logic [4:0] bar_beats;
    } in_item_t;

    typedef struct packed {
        logic [7:0] clock_mask;
        logic [7:0] gate_mask;
        logic       bar_start;
        logic       phrase_start;
        logic       any_gate;
        logic       odd_gates;
        logic       one_gate;
        logic       running;
        logic       reset_applied;
        logic [3:0] beat_in_bar;
        logic [3:0] bar_in_phrase;
    } out_item_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED0    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEED1    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RESEED   = 3'd6;

    localparam int CFG_DATA_W = 64;
    localparam logic [31:0] DIVISION_RESET = 32'h8765_4321;

    // channel index width covers the 8-bit masks
    localparam int CH_IDX_W = 3;

    // rate codes, named after their gate length in pulses
    localparam logic [3:0] RATE_48 = 4'd0;
    localparam logic [3:0] RATE_24 = 4'd1;
    localparam logic [3:0] RATE_12 = 4'd2;
    localparam logic [3:0] RATE_6  = 4'd3;
    localparam logic [3:0] RATE_3  = 4'd4;
    localparam logic [3:0] RATE_32 = 4'd5;
    localparam logic [3:0] RATE_16 = 4'd6;
    localparam logic [3:0] RATE_8  = 4'd7;
    localparam logic [3:0] RATE_4  = 4'd8;
    localparam logic [3:0] RATE_2  = 4'd9;

    typedef enum logic [1:0] {
        MODE_ALL,
        MODE_LINEAR,
        MODE_OFFBEAT,
        MODE_GLOBAL
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                load;
        logic                setup;
        logic                chan_step;
        logic [CH_IDX_W-1:0] chan;
        logic                push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [63:0] s0;
        logic [63:0] s1;
    } gen_t;

    // one xoroshiro128+ state update
    function automatic gen_t gen_advance(gen_t g);
        gen_t        r;
        logic [63:0] b;
        b    = g.s1 ^ g.s0;
        r.s0 = {g.s0[8:0], g.s0[63:9]} ^ b ^ (b << 14);
        r.s1 = {b[27:0], b[63:28]};
        return r;
    endfunction

    function automatic logic mode_passes(mode_t m, logic lin_shadow, logic off_shadow);
        return (m == MODE_ALL) || ((m == MODE_LINEAR) && !lin_shadow) ||
               ((m == MODE_OFFBEAT) && !off_shadow);
    endfunction

    // pulse divisible by the gate length; lengths with a factor of three use
    // the pulse count mod 3, the rest only the low pulse bits
    function automatic logic boundary_hit(logic [3:0] code, logic m3_zero, logic [4:0] low);
        logic hit;
        case (code)
            RATE_48: hit = m3_zero && (low[3:0] == 4'd0);
            RATE_24: hit = m3_zero && (low[2:0] == 3'd0);
            RATE_12: hit = m3_zero && (low[1:0] == 2'd0);
            RATE_6:  hit = m3_zero && !low[0];
            RATE_3:  hit = m3_zero;
            RATE_32: hit = (low == 5'd0);
            RATE_16: hit = (low[3:0] == 4'd0);
            RATE_8:  hit = (low[2:0] == 3'd0);
            RATE_4:  hit = (low[1:0] == 2'd0);
            default: hit = !low[0];
        endcase
        return hit;
    endfunction

endpackage

// ===== src/prgs_ctrl.sv =====
// ============================================================================
// prgs_ctrl
// Sequencer for one request: front-end update, reseed, one channel per
// cycle on a counted clock, then the result load.
// ============================================================================
module prgs_ctrl #(
    parameter int CHANNELS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  prgs_pkg::dp_status_t  status,
    output prgs_pkg::ctrl_cmd_t   cmd
);

    localparam logic [prgs_pkg::CH_IDX_W-1:0] LastCh = prgs_pkg::CH_IDX_W'(CHANNELS - 1);

    prgs_pkg::state_t              state_reg, state_next;
    logic [prgs_pkg::CH_IDX_W-1:0] chan_reg, chan_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prgs_pkg::ST_IDLE;
            chan_reg  <= '0;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        cmd        = '0;
        cmd.chan   = chan_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            prgs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = prgs_pkg::ST_SETUP;
                end
            end
            prgs_pkg::ST_SETUP: begin
                cmd.setup  = 1'b1;
                chan_next  = '0;
                state_next = status.tick ? prgs_pkg::ST_CHAN : prgs_pkg::ST_DONE;
            end
            prgs_pkg::ST_CHAN: begin
                cmd.chan_step = 1'b1;
                if (chan_reg == LastCh) begin
                    state_next = prgs_pkg::ST_DONE;
                end else begin
                    chan_next = chan_reg + prgs_pkg::CH_IDX_W'(1);
                end
            end
            prgs_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = prgs_pkg::ST_IDLE;
                end
            end
            default: state_next = prgs_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== src/prgs_dp.sv =====
// ============================================================================
// prgs_dp
// Datapath: configuration registers, run and counter state, the
// xoroshiro128+ generator, per-channel evaluation and the result register.
// ============================================================================
module prgs_dp #(
    parameter int MAX_STEPS       = 16,
    parameter int PULSES_PER_BEAT = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [prgs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [prgs_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  prgs_pkg::in_item_t                    s_data,
    input  prgs_pkg::ctrl_cmd_t                   cmd,
    output prgs_pkg::dp_status_t                  status,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output prgs_pkg::out_item_t                   m_data
);

    localparam int PhW = (PULSES_PER_BEAT > 1) ? $clog2(PULSES_PER_BEAT) : 1;
    localparam logic [PhW-1:0] PhLast = PhW'(PULSES_PER_BEAT - 1);
    localparam logic [4:0] MaxLen = 5'(MAX_STEPS);

    // configuration
    logic [63:0] dens_reg;
    logic [31:0] div_reg;
    logic [17:0] mode_reg;
    logic [8:0]  mute_reg;
    logic [63:0] seed0_reg, seed1_reg;
    logic        reseed_reg;

    // sequencer state
    logic           run_reg, pend_reg;
    logic [12:0]    pulse_reg;
    logic [PhW-1:0] beat_ph_reg;   // pulse count mod pulses per beat
    logic [1:0]     m3_reg;        // pulse count mod 3
    logic [3:0]     beat_reg, bar_reg;
    prgs_pkg::gen_t gen_reg;

    // per-request work
    logic       tick_reg, need_seed_reg;
    logic       new_bar_reg, new_phrase_reg, applied_reg;
    logic [7:0] cmask_reg, gmask_reg;
    logic [3:0] cnt_reg;
    logic       lin_ch_reg, lin_gl_reg, off_reg;

    logic                m_valid_reg;
    prgs_pkg::out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dens_reg   <= '0;
            div_reg    <= prgs_pkg::DIVISION_RESET;
            mode_reg   <= '0;
            mute_reg   <= '0;
            seed0_reg  <= '0;
            seed1_reg  <= '0;
            reseed_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                prgs_pkg::REG_DENSITY:  dens_reg   <= cfg_wr_data;
                prgs_pkg::REG_DIVISION: div_reg    <= cfg_wr_data[31:0];
                prgs_pkg::REG_MODE:     mode_reg   <= cfg_wr_data[17:0];
                prgs_pkg::REG_MUTE:     mute_reg   <= cfg_wr_data[8:0];
                prgs_pkg::REG_SEED0:    seed0_reg  <= cfg_wr_data;
                prgs_pkg::REG_SEED1:    seed1_reg  <= cfg_wr_data;
                prgs_pkg::REG_RESEED:   reseed_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- front end: run, reset request and counters ------------
    logic           run_n, pend_a, tick_n;
    logic [4:0]     max_bar, max_phrase;
    logic [12:0]    pc_inc;
    logic           pc_zero;
    logic [PhW-1:0] ph_inc;
    logic [1:0]     m3_inc;
    logic [4:0]     beat1, bar1;
    logic           pend_next;
    logic [12:0]    pulse_next;
    logic [PhW-1:0] beat_ph_next;
    logic [1:0]     m3_next;
    logic [3:0]     beat_next, bar_next;
    logic           nb_next, np_next, applied_next;

    always_comb begin
        run_n  = run_reg ^ s_data.run_toggle;
        pend_a = pend_reg | (s_data.run_toggle & run_n) | s_data.reset_edge;
        tick_n = s_data.clock_edge & run_n;

        max_bar = (s_data.bar_beats == 5'd0) ? 5'd1 :
                  ((s_data.bar_beats > MaxLen) ? MaxLen : s_data.bar_beats);
        max_phrase = (s_data.phrase_bars == 5'd0) ? 5'd1 :
                     ((s_data.phrase_bars > MaxLen) ? MaxLen : s_data.phrase_bars);

        pc_inc  = pulse_reg + 13'd1;
        pc_zero = (pc_inc == 13'd0);
        ph_inc  = (pc_zero || beat_ph_reg == PhLast) ? '0 : beat_ph_reg + PhW'(1);
        m3_inc  = (pc_zero || m3_reg == 2'd2) ? 2'd0 : m3_reg + 2'd1;
        beat1   = {1'b0, beat_reg} + {4'd0, (ph_inc == '0)};
        bar1    = {1'b0, bar_reg};

        pend_next    = pend_a;
        pulse_next   = pulse_reg;
        beat_ph_next = beat_ph_reg;
        m3_next      = m3_reg;
        beat_next    = beat_reg;
        bar_next     = bar_reg;
        nb_next      = 1'b0;
        np_next      = 1'b0;
        applied_next = 1'b0;

        if (tick_n) begin
            if (pend_a) begin
                pend_next    = 1'b0;
                pulse_next   = '0;
                beat_ph_next = '0;
                m3_next      = '0;
                beat_next    = '0;
                bar_next     = '0;
                nb_next      = 1'b1;
                np_next      = 1'b1;
                applied_next = 1'b1;
            end else begin
                pulse_next   = pc_inc;
                beat_ph_next = ph_inc;
                m3_next      = m3_inc;
                if (beat1 >= max_bar) begin
                    nb_next   = 1'b1;
                    beat_next = '0;
                    bar1      = bar1 + 5'd1;
                end else begin
                    beat_next = beat1[3:0];
                end
                // a shrunk phrase can wrap without a bar start
                if (bar1 >= max_phrase) begin
                    np_next      = 1'b1;
                    pulse_next   = '0;
                    beat_ph_next = '0;
                    m3_next      = '0;
                    bar_next     = '0;
                end else begin
                    bar_next = bar1[3:0];
                end
            end
        end
    end

    // ---------------- channel evaluation ----------------
    logic [3:0]     ch_code;
    logic           ch_hit;
    logic [63:0]    draw;
    logic [7:0]     ch_level;
    logic           ch_met, ch_muted;
    prgs_pkg::mode_t gmode, cmode;
    logic           pass_ch, pass_gl;

    always_comb begin
        ch_code  = div_reg[4*cmd.chan +: 4];
        ch_hit   = prgs_pkg::boundary_hit(ch_code, (m3_reg == 2'd0), pulse_reg[4:0]);
        draw     = gen_reg.s0 + gen_reg.s1;
        ch_level = dens_reg[8*cmd.chan +: 8];
        ch_met   = (ch_level == 8'hFF) || (draw[63:56] < ch_level);
        ch_muted = mute_reg[8] || mute_reg[cmd.chan];

        gmode = prgs_pkg::mode_t'(mode_reg[17:16]);
        if (gmode == prgs_pkg::MODE_GLOBAL) begin
            gmode = prgs_pkg::MODE_OFFBEAT;
        end
        // channel 0 always runs in all mode
        if (cmd.chan == '0) begin
            cmode = prgs_pkg::MODE_ALL;
        end else begin
            cmode = prgs_pkg::mode_t'(mode_reg[2*cmd.chan +: 2]);
        end
        if (cmode == prgs_pkg::MODE_GLOBAL) begin
            cmode = gmode;
        end

        pass_ch = ch_met && !ch_muted && prgs_pkg::mode_passes(cmode, lin_ch_reg, off_reg);
        pass_gl = ch_met && !ch_muted && prgs_pkg::mode_passes(gmode, lin_gl_reg, off_reg);
    end

    // ---------------- state registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            pulse_reg   <= '0;
            beat_ph_reg <= '0;
            m3_reg      <= '0;
            beat_reg    <= '0;
            bar_reg     <= '0;
            gen_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                run_reg     <= run_n;
                pend_reg    <= pend_next;
                pulse_reg   <= pulse_next;
                beat_ph_reg <= beat_ph_next;
                m3_reg      <= m3_next;
                beat_reg    <= beat_next;
                bar_reg     <= bar_next;
            end
            if (cmd.setup && need_seed_reg) begin
                gen_reg <= prgs_pkg::gen_advance({seed0_reg, seed1_reg});
            end else if (cmd.chan_step && ch_hit) begin
                gen_reg <= prgs_pkg::gen_advance(gen_reg);
            end
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // work registers are cleared by every request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tick_reg       <= tick_n;
            need_seed_reg  <= tick_n && np_next && reseed_reg;
            new_bar_reg    <= nb_next;
            new_phrase_reg <= np_next;
            applied_reg    <= applied_next;
            cmask_reg      <= '0;
            gmask_reg      <= '0;
            cnt_reg        <= '0;
            lin_ch_reg     <= 1'b0;
            lin_gl_reg     <= 1'b0;
            off_reg        <= 1'b0;
        end else if (cmd.chan_step && ch_hit) begin
            cmask_reg[cmd.chan] <= 1'b1;
            off_reg             <= 1'b1;
            if (pass_ch) begin
                gmask_reg[cmd.chan] <= 1'b1;
                lin_ch_reg          <= 1'b1;
            end
            if (pass_gl) begin
                cnt_reg    <= cnt_reg + 4'd1;
                lin_gl_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_data_reg.clock_mask    <= cmask_reg;
            m_data_reg.gate_mask     <= gmask_reg;
            m_data_reg.bar_start     <= new_bar_reg;
            m_data_reg.phrase_start  <= new_phrase_reg;
            m_data_reg.any_gate      <= (cnt_reg != 4'd0);
            m_data_reg.odd_gates     <= cnt_reg[0];
            m_data_reg.one_gate      <= (cnt_reg == 4'd1);
            m_data_reg.running       <= run_reg;
            m_data_reg.reset_applied <= applied_reg;
            m_data_reg.beat_in_bar   <= beat_reg;
            m_data_reg.bar_in_phrase <= bar_reg;
        end
    end

    assign status.tick     = tick_reg;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

endmodule

// ===== src/probabilistic_rhythm_gate_sequencer.sv =====
// ============================================================================
// probabilistic_rhythm_gate_sequencer
// Counts clock pulses into beats, bars and phrases and draws probabilistic
// gates for up to eight divided channels.
// ============================================================================
// One request at a time: the run state, the reset request and the counters
// update at the edge that takes a request. A request with a counted clock
// then passes through the reseed slot and the channel states, one channel
// after another, before its result is loaded; a request with no counted
// clock goes from the reseed slot straight to the result load. A new request
// is taken in the cycle after the result is loaded. The channels are stepped
// in order because the single shared xoroshiro128+ generator advances once
// for each channel at a boundary, in channel order. A result that waits on
// m_ready holds up the next request only at its final load step.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wr_data;
// the user must write it only while no request is in flight, as the block
// itself does not enforce this.
module probabilistic_rhythm_gate_sequencer #(
    parameter int CHANNELS        = 8,
    parameter int MAX_STEPS       = 16,
    parameter int PULSES_PER_BEAT = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [prgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prgs_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  prgs_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output prgs_pkg::out_item_t              m_data
);

    prgs_pkg::ctrl_cmd_t  cmd;
    prgs_pkg::dp_status_t status;

    prgs_ctrl #(
        .CHANNELS(CHANNELS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    prgs_dp #(
        .MAX_STEPS       (MAX_STEPS),
        .PULSES_PER_BEAT (PULSES_PER_BEAT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== src/prgs_chk.sv =====
// ============================================================================
// prgs_chk
// Port-level checks for the rhythm gate sequencer, bound to the top level.
// ============================================================================
module prgs_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input prgs_pkg::out_item_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // an applied reset starts a bar and a phrase at zero while running
    a_reset_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.reset_applied |->
            m_data.bar_start && m_data.phrase_start && m_data.running &&
            (m_data.beat_in_bar == 4'd0) && (m_data.bar_in_phrase == 4'd0))
        else $error("reset result malformed");

    // gates only on channels at a boundary; summary flags agree
    a_gate_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.gate_mask & ~m_data.clock_mask) == 8'd0) &&
            (!(m_data.one_gate || m_data.odd_gates) || m_data.any_gate))
        else $error("gate flags inconsistent");

    // nothing is counted while stopped
    a_stopped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.running |->
            (m_data.clock_mask == 8'd0) && !m_data.bar_start && !m_data.reset_applied)
        else $error("activity while stopped");

endmodule

bind probabilistic_rhythm_gate_sequencer prgs_chk u_prgs_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
